// File: hdl/hlfp_pkg.sv
// Shared types and constants for the header/length frame parser.
`timescale 1ns / 1ps
`default_nettype none

package hlfp_pkg;

  // Reset values of the header sync registers.
  localparam logic [7:0] HEADER_FIRST_RST  = 8'hEF;
  localparam logic [7:0] HEADER_SECOND_RST = 8'h12;

  // Configuration register indexes.
  localparam logic CFG_HEADER_FIRST  = 1'b0;
  localparam logic CFG_HEADER_SECOND = 1'b1;

  // Navigation decode qualifiers.
  localparam logic [7:0] NAVI_COMMAND = 8'd3;
  localparam logic [7:0] NAVI_MIN_LEN = 8'd4;

  // Payload byte positions that feed the navigation decode.
  localparam logic [7:0] POS_DIST_HI  = 8'd0;
  localparam logic [7:0] POS_DIST_MID = 8'd1;
  localparam logic [7:0] POS_DIST_LO  = 8'd2;
  localparam logic [7:0] POS_DIR      = 8'd3;

  // Frame phases, one-hot.
  typedef enum logic [6:0] {
    PH_HUNT1   = 7'b0000001,
    PH_HUNT2   = 7'b0000010,
    PH_CMD     = 7'b0000100,
    PH_LEN     = 7'b0001000,
    PH_PAYLOAD = 7'b0010000,
    PH_TAIL1   = 7'b0100000,
    PH_TAIL2   = 7'b1000000
  } hlfp_phase_e;

  // One completed frame as reported downstream.
  typedef struct packed {
    logic [7:0]  command;
    logic [7:0]  payload_length;
    logic [23:0] distance;
    logic [7:0]  direction;
    logic        navi_valid;
  } hlfp_result_t;

endpackage : hlfp_pkg

`default_nettype wire

// File: hdl/hlfp_parser.sv
// Frame phase state machine and navigation field capture.
`timescale 1ns / 1ps
`default_nettype none

module hlfp_parser
  import hlfp_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         step_i,
  input  wire logic [7:0]   rx_byte_i,
  input  wire logic [7:0]   header_first_i,
  input  wire logic [7:0]   header_second_i,
  output logic              last_o,
  output logic              done_o,
  output hlfp_result_t      result_o
);

  hlfp_phase_e phase_q, phase_d;
  logic [7:0]  command_q, command_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  left_q, left_d;
  logic [23:0] dist_q, dist_d;
  logic [7:0]  dir_q, dir_d;
  logic [7:0]  pos;

  // Index of the current payload byte within the payload.
  assign pos = len_q - left_q;

  // Next-state logic for one byte transfer.
  always_comb begin
    phase_d   = phase_q;
    command_d = command_q;
    len_d     = len_q;
    left_d    = left_q;
    dist_d    = dist_q;
    dir_d     = dir_q;
    done_o    = 1'b0;
    if (step_i) begin
      case (phase_q)
        PH_HUNT2: begin
          // The second-byte test wins when both header registers match.
          if (rx_byte_i == header_second_i) begin
            phase_d = PH_CMD;
          end else if (rx_byte_i == header_first_i) begin
            phase_d = PH_HUNT2;
          end else begin
            phase_d = PH_HUNT1;
          end
        end
        PH_CMD: begin
          command_d = rx_byte_i;
          dist_d    = '0;
          dir_d     = '0;
          phase_d   = PH_LEN;
        end
        PH_LEN: begin
          len_d   = rx_byte_i;
          left_d  = rx_byte_i;
          phase_d = (rx_byte_i == 8'd0) ? PH_TAIL1 : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          case (pos)
            POS_DIST_HI:  dist_d[23:16] = rx_byte_i;
            POS_DIST_MID: dist_d[15:8]  = rx_byte_i;
            POS_DIST_LO:  dist_d[7:0]   = rx_byte_i;
            POS_DIR:      dir_d         = rx_byte_i;
            default: ;
          endcase
          left_d = left_q - 8'd1;
          if (left_q == 8'd1) begin
            phase_d = PH_TAIL1;
          end
        end
        PH_TAIL1: begin
          phase_d = PH_TAIL2;
        end
        PH_TAIL2: begin
          phase_d = PH_HUNT1;
          done_o  = 1'b1;
        end
        default: begin
          phase_d = (rx_byte_i == header_first_i) ? PH_HUNT2 : PH_HUNT1;
        end
      endcase
    end
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HUNT1;
      command_q <= '0;
      len_q     <= '0;
      left_q    <= '0;
      dist_q    <= '0;
      dir_q     <= '0;
    end else begin
      phase_q   <= phase_d;
      command_q <= command_d;
      len_q     <= len_d;
      left_q    <= left_d;
      dist_q    <= dist_d;
      dir_q     <= dir_d;
    end
  end

  // The next byte closes a frame when the second tail byte is due.
  assign last_o = (phase_q == PH_TAIL2);

  // Result fields come straight from the captured frame state.
  assign result_o.command        = command_q;
  assign result_o.payload_length = len_q;
  assign result_o.distance       = dist_q;
  assign result_o.direction      = dir_q;
  assign result_o.navi_valid     = (command_q == NAVI_COMMAND) && (len_q >= NAVI_MIN_LEN);

endmodule : hlfp_parser

`default_nettype wire

// File: hdl/header_length_frame_parser_core.sv
// Top level of the header/length frame parser with navigation decode.
// A result appears on the outputs in the cycle after the transfer of a frame's
// second tail byte.
// Throughput: one byte per cycle; the input stalls only while a finished result is held
// and the next byte would close another frame.
// Reset clears the frame state to the header hunt, the header registers to 0xEF/0x12,
// and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module header_length_frame_parser_core
  import hlfp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [7:0]  cfg_data_i,
  // Byte input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  // Frame result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       command_o,
  output logic [7:0]       payload_length_o,
  output logic [23:0]      distance_o,
  output logic [7:0]       direction_o,
  output logic             navi_valid_o
);

  logic [7:0]   header_first_q;
  logic [7:0]   header_second_q;
  logic         in_accept;
  logic         last;
  logic         done;
  hlfp_result_t result;
  hlfp_result_t out_q;
  logic         out_valid_q;

  // Header sync registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_first_q  <= HEADER_FIRST_RST;
      header_second_q <= HEADER_SECOND_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_HEADER_FIRST:  header_first_q  <= cfg_data_i;
        CFG_HEADER_SECOND: header_second_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Hold off only a byte that would produce a result the output cannot take.
  assign in_stall_o = out_valid_q && out_stall_i && last;
  assign in_accept  = in_valid_i && !in_stall_o;

  hlfp_parser u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (in_accept),
    .rx_byte_i       (rx_byte_i),
    .header_first_i  (header_first_q),
    .header_second_i (header_second_q),
    .last_o          (last),
    .done_o          (done),
    .result_o        (result)
  );

  // Output valid: set by a completed frame, cleared by a transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (done) begin
      out_q <= result;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign command_o        = out_q.command;
  assign payload_length_o = out_q.payload_length;
  assign distance_o       = out_q.distance;
  assign direction_o      = out_q.direction;
  assign navi_valid_o     = out_q.navi_valid;

endmodule : header_length_frame_parser_core

`default_nettype wire

// File: hdl/hlfp_checker.sv
// Port-level assertions for the frame parser and their bind.
`timescale 1ns / 1ps
`default_nettype none

module hlfp_checker
  import hlfp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_stall_o,
  input  wire logic        out_valid_o,
  input  wire logic        out_stall_i,
  input  wire logic [7:0]  command_o,
  input  wire logic [7:0]  payload_length_o,
  input  wire logic [23:0] distance_o,
  input  wire logic [7:0]  direction_o,
  input  wire logic        navi_valid_o
);

  // A stalled result stays valid and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(command_o)
      && $stable(payload_length_o) && $stable(distance_o) && $stable(direction_o))
    else $error("stalled result changed");

  // The input is held off only while a result waits downstream.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

  // The navigation flag needs the navigation command and at least four payload bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && navi_valid_o |-> command_o == NAVI_COMMAND
      && payload_length_o >= NAVI_MIN_LEN)
    else $error("navigation flag without qualifying frame");

  // An empty payload leaves distance and direction at zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && payload_length_o == 8'd0 |-> distance_o == 24'd0 && direction_o == 8'd0)
    else $error("empty frame carries navigation data");

  // A one-byte payload fills only the leading distance byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && payload_length_o == 8'd1 |-> distance_o[15:0] == 16'd0
      && direction_o == 8'd0)
    else $error("one-byte frame carries extra navigation data");

endmodule : hlfp_checker

bind header_length_frame_parser_core hlfp_checker u_hlfp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .command_o        (command_o),
  .payload_length_o (payload_length_o),
  .distance_o       (distance_o),
  .direction_o      (direction_o),
  .navi_valid_o     (navi_valid_o)
);

`default_nettype wire
